@@ design/byte_ring_fifo_assert.svh @@
// Assertion macros used by the byte ring FIFO controller.
`ifndef BYTE_RING_FIFO_ASSERT_SVH
`define BYTE_RING_FIFO_ASSERT_SVH

`ifndef SYNTHESIS
// Property checked on every rising edge, ignored while reset is high.
`define BRF_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Condition that must never be seen outside reset.
`define BRF_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define BRF_ASSERT(lbl, clk, rst, prop, msg)
`define BRF_NEVER(lbl, clk, rst, cond, msg)
`endif

`endif

@@ design/brf_pkg.sv @@
// Package with types, codes and pointer helpers of the byte ring FIFO.
package brf_pkg;

  localparam int DEPTH = 64;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = 6;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;

  localparam logic [2:0] MODE_WR_START = 3'd0;
  localparam logic [2:0] MODE_WR_BYTE  = 3'd1;
  localparam logic [2:0] MODE_READ     = 3'd2;
  localparam logic [2:0] MODE_PEEK     = 3'd3;
  localparam logic [2:0] MODE_DROP     = 3'd4;
  localparam logic [2:0] MODE_CLEAR    = 3'd5;

  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_NO_ROOM    = 2'd1;
  localparam logic [1:0] STATUS_EMPTY      = 2'd2;
  localparam logic [1:0] STATUS_UNEXPECTED = 2'd3;

  // Depth and capacity as count values (depth 64 wraps to 0, which is exact mod 64).
  localparam cnt_t DEPTH_CNT = CNT_W'(DEPTH % (1 << CNT_W));
  localparam cnt_t CAP_CNT   = CNT_W'(DEPTH - 1);

  typedef struct packed {
    logic [2:0] mode;
    cnt_t       length;
    logic [7:0] data_byte;
  } brf_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic [1:0] status;
    cnt_t       used_count;
    cnt_t       free_count;
  } brf_out_t;

  // Result control from the sequencer to the top level.
  typedef struct packed {
    logic       valid;
    logic       from_ram;
    logic       last;
    logic [1:0] status;
    cnt_t       used;
  } brf_rsp_t;

  // Pointer plus a count below DEPTH, wrapped at DEPTH.
  function automatic ptr_t ptr_add(ptr_t p, cnt_t n);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(p) + (CNT_W+1)'(n);
    if (s >= (CNT_W+1)'(DEPTH)) begin
      s = s - (CNT_W+1)'(DEPTH);
    end
    return PTR_W'(s);
  endfunction

  function automatic cnt_t used_of(ptr_t head, ptr_t tail);
    cnt_t d;
    d = CNT_W'(tail) - CNT_W'(head);
    if (head > tail) begin
      d = d + DEPTH_CNT;
    end
    return d;
  endfunction

endpackage

@@ design/brf_ram.sv @@
// Generic simple dual-port RAM with a registered read port.
module brf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ design/brf_ctrl.sv @@
// Pointer state, command decode and read sequencer of the byte ring FIFO.
module brf_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  brf_pkg::brf_in_t cmd,
  output logic             ram_we,
  output brf_pkg::ptr_t    ram_waddr,
  output logic [7:0]       ram_wdata,
  output logic             ram_re,
  output brf_pkg::ptr_t    ram_raddr,
  output brf_pkg::brf_rsp_t rsp
);
  import brf_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic       state, state_next;
  ptr_t       head, head_next;
  ptr_t       tail, tail_next;
  ptr_t       stage, stage_next;
  cnt_t       pending, pending_next;
  ptr_t       rd_ptr, rd_ptr_next;
  cnt_t       remaining, remaining_next;
  logic       rsp_valid, rsp_valid_next;
  logic       rsp_from_ram, rsp_from_ram_next;
  logic       rsp_last, rsp_last_next;
  logic [1:0] rsp_status, rsp_status_next;

  logic accept;
  cnt_t used, free, take;

  assign busy   = (state == ST_READ);
  assign accept = start && !busy;
  assign used   = used_of(head, tail);
  assign free   = CAP_CNT - used;
  assign take   = (cmd.length < used) ? cmd.length : used;

  assign ram_we    = accept && (cmd.mode == MODE_WR_BYTE) && (pending != '0);
  assign ram_waddr = stage;
  assign ram_wdata = cmd.data_byte;
  assign ram_re    = busy;
  assign ram_raddr = rd_ptr;

  always_comb begin
    state_next        = state;
    head_next         = head;
    tail_next         = tail;
    stage_next        = stage;
    pending_next      = pending;
    rd_ptr_next       = rd_ptr;
    remaining_next    = remaining;
    rsp_valid_next    = 1'b0;
    rsp_from_ram_next = 1'b0;
    rsp_last_next     = 1'b1;
    rsp_status_next   = STATUS_OK;

    if (busy) begin
      // One byte is read per cycle; its data leaves the RAM in the next cycle.
      rsp_valid_next    = 1'b1;
      rsp_from_ram_next = 1'b1;
      rsp_last_next     = (remaining == cnt_t'(1));
      rd_ptr_next       = ptr_add(rd_ptr, cnt_t'(1));
      remaining_next    = remaining - cnt_t'(1);
      if (remaining == cnt_t'(1)) begin
        state_next = ST_IDLE;
      end
    end else if (accept) begin
      rsp_valid_next = 1'b1;
      case (cmd.mode)
        MODE_WR_START: begin
          pending_next = '0;
          if (cmd.length > free) begin
            rsp_status_next = STATUS_NO_ROOM;
          end else if (cmd.length != '0) begin
            stage_next   = tail;
            pending_next = cmd.length;
          end
        end
        MODE_WR_BYTE: begin
          if (pending == '0) begin
            rsp_status_next = STATUS_UNEXPECTED;
          end else begin
            stage_next   = ptr_add(stage, cnt_t'(1));
            pending_next = pending - cnt_t'(1);
            if (pending == cnt_t'(1)) begin
              tail_next = ptr_add(stage, cnt_t'(1));
            end
          end
        end
        MODE_READ, MODE_PEEK: begin
          if (take == '0) begin
            rsp_status_next = STATUS_EMPTY;
          end else begin
            rsp_valid_next = 1'b0;
            rd_ptr_next    = head;
            remaining_next = take;
            state_next     = ST_READ;
            if (cmd.mode == MODE_READ) begin
              head_next = ptr_add(head, take);
            end
          end
        end
        MODE_DROP: begin
          head_next = ptr_add(head, take);
        end
        MODE_CLEAR: begin
          head_next    = '0;
          tail_next    = '0;
          stage_next   = '0;
          pending_next = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= '0;
      tail      <= '0;
      stage     <= '0;
      pending   <= '0;
      remaining <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      tail      <= tail_next;
      stage     <= stage_next;
      pending   <= pending_next;
      remaining <= remaining_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_ptr       <= rd_ptr_next;
    rsp_from_ram <= rsp_from_ram_next;
    rsp_last     <= rsp_last_next;
    rsp_status   <= rsp_status_next;
  end

  // Counts follow the pointers: they only change when the next word is taken.
  assign rsp.valid    = rsp_valid;
  assign rsp.from_ram = rsp_from_ram;
  assign rsp.last     = rsp_last;
  assign rsp.status   = rsp_status;
  assign rsp.used     = used;

`include "byte_ring_fifo_assert.svh"

  `BRF_NEVER(a_no_write_in_read, clk, rst, busy && ram_we, "RAM write during a read burst")
  `BRF_ASSERT(a_burst_nonempty, clk, rst, busy |-> (remaining != '0), "read burst with no bytes")
  `BRF_ASSERT(a_read_gives_word, clk, rst, busy |=> (rsp_valid && rsp_from_ram), "read lost")
  `BRF_ASSERT(a_word_needs_cmd, clk, rst, (rsp_valid && !rsp_from_ram) |-> $past(accept), "result without command")

endmodule

@@ design/byte_ring_fifo.sv @@
// Top level of the byte ring FIFO: sequencer, byte RAM and result formatting.
//
//   channel  | handshake              | payload
//   ---------+------------------------+---------------------------
//   command  | start, busy            | cmd    (brf_in_t)
//   result   | strobe (one cycle)     | result (brf_out_t)
//
// Every command except a read or peek that returns data leaves busy low, and
// its result word appears in the next cycle; such commands may follow every cycle.
// A read or peek of n bytes holds busy high while it makes one RAM read per cycle,
// and each of its n result words appears in the cycle after its RAM read.
// Reset clears the head, tail and write staging pointers; the byte RAM keeps no reset state.
// The receiver cannot stall: each result word is shown for exactly one cycle.
module byte_ring_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  brf_pkg::brf_in_t  cmd,
  output logic              strobe,
  output brf_pkg::brf_out_t result
);
  import brf_pkg::*;

  logic       ram_we, ram_re;
  ptr_t       ram_waddr, ram_raddr;
  logic [7:0] ram_wdata, ram_rdata;
  brf_rsp_t   rsp;

  brf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .rsp       (rsp)
  );

  brf_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign strobe            = rsp.valid;
  assign result.out_byte   = rsp.from_ram ? ram_rdata : 8'd0;
  assign result.last       = rsp.last;
  assign result.status     = rsp.status;
  assign result.used_count = rsp.used;
  assign result.free_count = CAP_CNT - rsp.used;

endmodule

@@ verif/byte_ring_fifo_tb.sv @@
// Self-checking testbench for byte_ring_fifo: directed table, random block traffic, scoreboard.
module byte_ring_fifo_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import brf_pkg::*;

  localparam logic [2:0] MODE_SPARE6 = 3'd6;
  localparam logic [2:0] MODE_SPARE7 = 3'd7;
  localparam int N_DIRECTED = 26;
  localparam int N_ITEMS = 430;

  localparam brf_out_t EMPTY_AT_0   = '{8'h00, 1'b1, STATUS_EMPTY, 6'd0, 6'd63};
  localparam brf_out_t OK_AT_0      = '{8'h00, 1'b1, STATUS_OK, 6'd0, 6'd63};
  localparam brf_out_t STRAY_AT_0   = '{8'h00, 1'b1, STATUS_UNEXPECTED, 6'd0, 6'd63};
  localparam brf_out_t NO_ROOM_AT_2 = '{8'h00, 1'b1, STATUS_NO_ROOM, 6'd2, 6'd61};

  typedef struct packed {
    brf_in_t  c;
    logic     typed;
    brf_out_t w;
  } dir_row_t;

  logic     clk;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  logic     busy;
  brf_in_t  cmd = '0;
  logic     strobe;
  brf_out_t result;

  byte_ring_fifo uut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .strobe (strobe),
    .result (result)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Shadow of the FIFO contents and pointers.
  logic [7:0] shadow_mem [DEPTH];
  int head_idx = 0;
  int tail_idx = 0;
  int stage_idx = 0;
  int pending_bytes = 0;

  brf_out_t expected_words [$];
  brf_out_t want;
  int fails = 0;
  int items_sent = 0;
  int words_seen = 0;
  int data_words = 0;
  int peak_fill = 0;
  int full_hits = 0;
  logic idle_on = 1'b1;
  dir_row_t directed_rows [N_DIRECTED];

  function automatic int fill_level();
    if (head_idx > tail_idx) begin
      return DEPTH - head_idx + tail_idx;
    end
    return tail_idx - head_idx;
  endfunction

  function automatic int room_left();
    return DEPTH - 1 - fill_level();
  endfunction

  function automatic brf_out_t status_word(logic [7:0] b, logic l, logic [1:0] s);
    brf_out_t w;
    w.out_byte   = b;
    w.last       = l;
    w.status     = s;
    w.used_count = cnt_t'(fill_level());
    w.free_count = cnt_t'(room_left());
    return w;
  endfunction

  function automatic brf_in_t cmd_word(logic [2:0] m, int len);
    brf_in_t c;
    c.mode      = m;
    c.length    = cnt_t'(len);
    c.data_byte = 8'($urandom_range(255));
    return c;
  endfunction

  function automatic int pick_len();
    case ($urandom_range(9))
      0: begin
        return 63;
      end
      1: begin
        return 0;
      end
      2: begin
        return $urandom_range(1, 63);
      end
      default: begin
        return $urandom_range(1, 12);
      end
    endcase
  endfunction

  function automatic void note_fail(string msg);
    fails++;
    if (fails <= 10) begin
      $display("ERROR @%0t: %s", $realtime, msg);
    end
  endfunction

  // Applies one accepted word to the shadow state and queues its result words.
  task automatic predict(input brf_in_t c, input logic typed, input brf_out_t typed_word);
    int n;
    int first;
    int i;
    logic [1:0] st;
    logic multi;
    st = STATUS_OK;
    multi = 1'b0;
    case (c.mode)
      MODE_WR_START: begin
        pending_bytes = 0;
        if (int'(c.length) > room_left()) begin
          st = STATUS_NO_ROOM;
        end else if (c.length != 0) begin
          stage_idx = tail_idx;
          pending_bytes = int'(c.length);
        end
      end
      MODE_WR_BYTE: begin
        if (pending_bytes == 0) begin
          st = STATUS_UNEXPECTED;
        end else begin
          shadow_mem[stage_idx] = c.data_byte;
          stage_idx = (stage_idx + 1) % DEPTH;
          pending_bytes--;
          // The block becomes visible only with its final byte.
          if (pending_bytes == 0) begin
            tail_idx = stage_idx;
            if (fill_level() == DEPTH - 1) begin
              full_hits++;
            end
          end
        end
      end
      MODE_READ, MODE_PEEK: begin
        n = fill_level();
        if (int'(c.length) < n) begin
          n = int'(c.length);
        end
        if (n == 0) begin
          st = STATUS_EMPTY;
        end else begin
          multi = 1'b1;
          first = head_idx;
          if (c.mode == MODE_READ) begin
            head_idx = (head_idx + n) % DEPTH;
          end
          for (i = 0; i < n; i++) begin
            expected_words.push_back(status_word(shadow_mem[(first + i) % DEPTH],
                                                 i == n - 1, STATUS_OK));
          end
          data_words += n;
        end
      end
      MODE_DROP: begin
        n = fill_level();
        if (int'(c.length) < n) begin
          n = int'(c.length);
        end
        head_idx = (head_idx + n) % DEPTH;
      end
      MODE_CLEAR: begin
        head_idx = 0;
        tail_idx = 0;
        stage_idx = 0;
        pending_bytes = 0;
      end
      default: begin
      end
    endcase
    if (typed) begin
      expected_words.push_back(typed_word);
    end else if (!multi) begin
      expected_words.push_back(status_word(8'h00, 1'b1, st));
    end
    if (fill_level() > peak_fill) begin
      peak_fill = fill_level();
    end
  endtask

  // Presents one command word, holds it until accepted, then predicts it.
  task automatic issue(input brf_in_t c, input logic typed = 1'b0,
                       input brf_out_t typed_word = '0);
    if (idle_on && $urandom_range(99) < 12) begin
      start <= 1'b0;
      cmd <= brf_in_t'($urandom);
      @(posedge clk);
    end
    start <= 1'b1;
    cmd <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict(c, typed, typed_word);
    if (c.mode <= MODE_CLEAR) begin
      items_sent++;
    end
    idle_on = !(items_sent >= 180 && items_sent < 300);
  endtask

  always @(posedge clk) begin
    if (!rst && strobe) begin
      words_seen++;
      if (expected_words.size() == 0) begin
        note_fail($sformatf("result word %h arrived with nothing expected", result));
      end else begin
        want = expected_words.pop_front();
        if (result.out_byte !== want.out_byte || result.last !== want.last ||
            result.status !== want.status || result.used_count !== want.used_count ||
            result.free_count !== want.free_count) begin
          note_fail($sformatf(
            "exp byte=%h last=%b st=%0d used=%0d free=%0d, got byte=%h last=%b st=%0d used=%0d free=%0d",
            want.out_byte, want.last, want.status, want.used_count, want.free_count,
            result.out_byte, result.last, result.status, result.used_count,
            result.free_count));
        end
      end
    end
  end

  initial begin
    int roll;
    int room;
    int blk;
    int stop_at;
    int j;
    int k;
    directed_rows = '{
      '{'{MODE_READ,     6'd5,  8'h00}, 1'b1, EMPTY_AT_0},
      '{'{MODE_PEEK,     6'd0,  8'hFF}, 1'b1, EMPTY_AT_0},
      '{'{MODE_WR_BYTE,  6'd0,  8'hFF}, 1'b1, STRAY_AT_0},
      '{'{MODE_DROP,     6'd63, 8'h00}, 1'b1, OK_AT_0},
      '{'{MODE_WR_START, 6'd63, 8'h00}, 1'b1, OK_AT_0},
      '{'{MODE_WR_START, 6'd0,  8'h00}, 1'b1, OK_AT_0},
      '{'{MODE_WR_BYTE,  6'd63, 8'h80}, 1'b1, STRAY_AT_0},
      '{'{MODE_WR_START, 6'd3,  8'h00}, 1'b1, OK_AT_0},
      '{'{MODE_WR_BYTE,  6'd0,  8'h00}, 1'b0, '0},
      '{'{MODE_WR_BYTE,  6'd63, 8'hFF}, 1'b0, '0},
      '{'{MODE_WR_BYTE,  6'd0,  8'h5A}, 1'b0, '0},
      '{'{MODE_PEEK,     6'd63, 8'h00}, 1'b0, '0},
      '{'{MODE_READ,     6'd1,  8'h00}, 1'b0, '0},
      '{'{MODE_WR_START, 6'd62, 8'h00}, 1'b1, NO_ROOM_AT_2},
      '{'{MODE_WR_START, 6'd2,  8'h00}, 1'b0, '0},
      '{'{MODE_WR_BYTE,  6'd0,  8'h11}, 1'b0, '0},
      '{'{MODE_WR_START, 6'd1,  8'h00}, 1'b0, '0},
      '{'{MODE_WR_BYTE,  6'd0,  8'h22}, 1'b0, '0},
      '{'{MODE_WR_START, 6'd2,  8'h00}, 1'b0, '0},
      '{'{MODE_CLEAR,    6'd0,  8'h00}, 1'b1, OK_AT_0},
      '{'{MODE_WR_BYTE,  6'd0,  8'h33}, 1'b1, STRAY_AT_0},
      '{'{MODE_SPARE6,   6'd63, 8'hFF}, 1'b1, OK_AT_0},
      '{'{MODE_SPARE7,   6'd0,  8'h00}, 1'b1, OK_AT_0},
      '{'{MODE_WR_START, 6'd1,  8'h00}, 1'b0, '0},
      '{'{MODE_WR_BYTE,  6'd0,  8'hC3}, 1'b0, '0},
      '{'{MODE_DROP,     6'd63, 8'h00}, 1'b0, '0}
    };

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (k = 0; k < N_DIRECTED; k++) begin
      issue(directed_rows[k].c, directed_rows[k].typed, directed_rows[k].w);
    end

    // Mostly complete write blocks and reads, with refused, abandoned and stray words mixed in.
    while (items_sent < N_ITEMS) begin
      roll = $urandom_range(99);
      room = room_left();
      if (roll < 40 && room > 0) begin
        if ($urandom_range(3) == 0) begin
          blk = room;
        end else begin
          blk = $urandom_range(1, 10);
          if (blk > room) begin
            blk = room;
          end
        end
        stop_at = ($urandom_range(9) == 0) ? $urandom_range(0, blk - 1) : blk;
        issue(cmd_word(MODE_WR_START, blk));
        for (j = 0; j < stop_at; j++) begin
          issue(cmd_word(MODE_WR_BYTE, $urandom_range(63)));
        end
      end else if (roll < 62) begin
        issue(cmd_word(MODE_READ, pick_len()));
      end else if (roll < 74) begin
        issue(cmd_word(MODE_PEEK, pick_len()));
      end else if (roll < 84) begin
        issue(cmd_word(MODE_DROP, pick_len()));
      end else if (roll < 87) begin
        issue(cmd_word(MODE_CLEAR, $urandom_range(63)));
      end else if (roll < 93) begin
        if (room < 63) begin
          issue(cmd_word(MODE_WR_START, $urandom_range(room + 1, 63)));
        end else begin
          issue(cmd_word(MODE_WR_START, $urandom_range(63)));
        end
      end else begin
        case ($urandom_range(3))
          0: begin
            issue(cmd_word(MODE_WR_BYTE, $urandom_range(63)));
          end
          1: begin
            issue(cmd_word(MODE_SPARE6, $urandom_range(63)));
          end
          2: begin
            issue(cmd_word(MODE_SPARE7, $urandom_range(63)));
          end
          default: begin
            issue(cmd_word(MODE_WR_START, 0));
          end
        endcase
      end
    end

    start <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Run covered %0d commands and %0d checked result words, %0d of them data bytes.",
             items_sent, words_seen, data_words);
    $display("Highest fill was %0d of %0d bytes; the FIFO was filled to capacity %0d times.",
             peak_fill, DEPTH - 1, full_hits);
    if (fails == 0) begin
      $display("byte_ring_fifo regression: pass");
    end else begin
      $display("%0d mismatches in total", fails);
      $display("byte_ring_fifo regression: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d result words still expected", expected_words.size());
    $display("byte_ring_fifo regression: fail");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/brf_pkg.sv
design/brf_ram.sv
design/brf_ctrl.sv
design/byte_ring_fifo.sv
verif/byte_ring_fifo_tb.sv
